@@ rtl/core/f2i8q_pkg.sv @@
// Types and constants shared by the float-to-int8 quantizer.
// No dependencies; every other file in rtl/core imports this package.
package f2i8q_pkg;

    localparam int unsigned QuoBits = 27;           // quotient bits q0..q26
    localparam logic [31:0] ScaleReset = 32'h3f80_0000;
    localparam logic [6:0] MagNan = 7'd64;
    localparam logic [6:0] MagMax = 7'd127;
    localparam logic [6:0] MagZero = 7'd0;

    typedef struct packed {
        logic [31:0] value_bits;
        logic        last_in;
    } in_beat_t;

    typedef struct packed {
        logic signed [7:0] quantized;
        logic              last_out;
    } out_beat_t;

    // after decode: operand classes resolved, mantissas not yet normalized
    typedef struct packed {
        logic        last;
        logic        neg;
        logic        fixed;
        logic [6:0]  fixed_mag;
        logic [7:0]  exp_a;
        logic [4:0]  lz_a;
        logic [23:0] sig_a;
        logic [7:0]  exp_b;
        logic [4:0]  lz_b;
        logic [23:0] sig_b;
    } unpack_t;

    // divider pipeline payload
    typedef struct packed {
        logic                 last;
        logic                 neg;
        logic                 fixed;
        logic [6:0]           fixed_mag;
        logic [3:0]           sh;
        logic [23:0]          div;
        logic [24:0]          rem;
        logic [QuoBits-1:0]   quo;
    } work_t;

    // after rounding the quotient to single precision
    typedef struct packed {
        logic        last;
        logic        neg;
        logic        fixed;
        logic [6:0]  fixed_mag;
        logic [3:0]  k;
        logic [23:0] sig;
    } rnd_t;

endpackage

@@ rtl/core/f2i8q_unpack.sv @@
// Decode stage: classifies value and scale, counts mantissa leading zeros.
// Depends on f2i8q_pkg.
module f2i8q_unpack (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  f2i8q_pkg::in_beat_t in_data,
    input  logic [31:0]         scale,
    output logic                out_valid,
    input  logic                out_ready,
    output f2i8q_pkg::unpack_t  out_data
);
    import f2i8q_pkg::*;

    logic    vld_reg;
    unpack_t data_reg;
    unpack_t data_next;

    function automatic logic [4:0] lzc24(input logic [23:0] s);
        logic [4:0] n;
        n = 5'd0;
        for (int i = 0; i < 24; i++) begin
            if (s[i]) begin
                n = 5'(23 - i);
            end
        end
        return n;
    endfunction

    logic [31:0] v;
    logic        nan_v, inf_v, zero_v, nan_s, inf_s, zero_s;

    always_comb begin
        v      = in_data.value_bits;
        nan_v  = (v[30:23] == 8'hff) && (v[22:0] != 23'd0);
        inf_v  = (v[30:0] == 31'h7f80_0000);
        zero_v = (v[30:0] == 31'd0);
        nan_s  = (scale[30:23] == 8'hff) && (scale[22:0] != 23'd0);
        inf_s  = (scale[30:0] == 31'h7f80_0000);
        zero_s = (scale[30:0] == 31'd0);

        data_next.last      = in_data.last_in;
        data_next.neg       = v[31] ^ scale[31];
        data_next.fixed     = 1'b1;
        data_next.fixed_mag = MagZero;
        data_next.sig_a     = {(v[30:23] != 8'd0), v[22:0]};
        data_next.sig_b     = {(scale[30:23] != 8'd0), scale[22:0]};
        data_next.exp_a     = (v[30:23] == 8'd0) ? 8'd1 : v[30:23];
        data_next.exp_b     = (scale[30:23] == 8'd0) ? 8'd1 : scale[30:23];
        data_next.lz_a      = lzc24(data_next.sig_a);
        data_next.lz_b      = lzc24(data_next.sig_b);

        priority if (nan_v) begin
            data_next.fixed_mag = MagNan;
            data_next.neg       = v[31];
        end else if (nan_s) begin
            data_next.fixed_mag = MagNan;
            data_next.neg       = scale[31];
        end else if ((zero_v && zero_s) || (inf_v && inf_s)) begin
            data_next.fixed_mag = MagNan;
            data_next.neg       = 1'b0;
        end else if (inf_v || zero_s) begin
            data_next.fixed_mag = MagMax;
        end else if (inf_s || zero_v) begin
            data_next.fixed_mag = MagZero;
        end else begin
            data_next.fixed = 1'b0;
        end
    end

    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_ready) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

@@ rtl/core/f2i8q_align.sv @@
// Normalize stage: shifts mantissas left, forms exponent difference and range.
// Depends on f2i8q_pkg.
module f2i8q_align (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  f2i8q_pkg::unpack_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output f2i8q_pkg::work_t   out_data
);
    import f2i8q_pkg::*;

    logic              vld_reg;
    work_t             data_reg;
    work_t             data_next;
    logic signed [9:0] e_a, e_b, d;
    logic [23:0]       norm_a;

    always_comb begin
        e_a    = $signed({2'b00, in_data.exp_a}) - $signed({5'd0, in_data.lz_a});
        e_b    = $signed({2'b00, in_data.exp_b}) - $signed({5'd0, in_data.lz_b});
        d      = e_a - e_b;
        norm_a = in_data.sig_a << in_data.lz_a;

        data_next.last      = in_data.last;
        data_next.neg       = in_data.neg;
        data_next.fixed     = in_data.fixed;
        data_next.fixed_mag = in_data.fixed_mag;
        data_next.div       = in_data.sig_b << in_data.lz_b;
        data_next.rem       = {1'b0, norm_a};
        data_next.quo       = '0;
        data_next.sh        = 4'(-d);
        // quotient above one saturates; below 2^-10 it rounds to zero
        if (!in_data.fixed) begin
            if (d > 10'sd0) begin
                data_next.fixed     = 1'b1;
                data_next.fixed_mag = MagMax;
            end else if (d < -10'sd10) begin
                data_next.fixed     = 1'b1;
                data_next.fixed_mag = MagZero;
            end
        end
    end

    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_ready) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

@@ rtl/core/f2i8q_div_step.sv @@
// One restoring-division stage: produces one quotient bit per beat.
// Depends on f2i8q_pkg.
module f2i8q_div_step (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  f2i8q_pkg::work_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output f2i8q_pkg::work_t out_data
);
    import f2i8q_pkg::*;

    logic        vld_reg;
    work_t       data_reg;
    work_t       data_next;
    logic [24:0] diff;
    logic        bit_q;

    always_comb begin
        diff      = in_data.rem - {1'b0, in_data.div};
        bit_q     = (in_data.rem >= {1'b0, in_data.div});
        data_next = in_data;
        // remainder stays below the divisor, so the shift fits 25 bits
        data_next.rem = (bit_q ? diff : in_data.rem) << 1;
        data_next.quo = {in_data.quo[QuoBits-2:0], bit_q};
    end

    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_ready) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

@@ rtl/core/f2i8q_round.sv @@
// Rounds the quotient to a single-precision significand (nearest even).
// Depends on f2i8q_pkg.
module f2i8q_round (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  f2i8q_pkg::work_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output f2i8q_pkg::rnd_t  out_data
);
    import f2i8q_pkg::*;

    logic              vld_reg;
    rnd_t              data_reg;
    rnd_t              data_next;
    logic              q0, g, st;
    logic [23:0]       sig;
    logic [24:0]       sum;
    logic signed [5:0] k;

    always_comb begin
        q0 = in_data.quo[QuoBits-1];
        if (q0) begin
            sig = in_data.quo[26:3];
            g   = in_data.quo[2];
            st  = (in_data.quo[1:0] != 2'd0) || (in_data.rem != 25'd0);
        end else begin
            sig = in_data.quo[25:2];
            g   = in_data.quo[1];
            st  = in_data.quo[0] || (in_data.rem != 25'd0);
        end
        sum = {1'b0, sig} + {24'd0, (g && (st || sig[0]))};
        // k is minus the exponent of the rounded value's leading bit
        k   = $signed({2'b00, in_data.sh}) + $signed({5'd0, !q0}) - $signed({5'd0, sum[24]});

        data_next.last      = in_data.last;
        data_next.neg       = in_data.neg;
        data_next.fixed     = in_data.fixed;
        data_next.fixed_mag = in_data.fixed_mag;
        data_next.sig       = sum[24] ? 24'h80_0000 : sum[23:0];
        data_next.k         = k[3:0];
        // value at or above one clamps to full scale
        if (!in_data.fixed && (k <= 6'sd0)) begin
            data_next.fixed     = 1'b1;
            data_next.fixed_mag = MagMax;
        end
    end

    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_ready) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

@@ rtl/core/f2i8q_pack.sv @@
// Output stage: adds 1.0 in single precision, takes the 7-bit magnitude, signs it.
// Depends on f2i8q_pkg.
module f2i8q_pack (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  f2i8q_pkg::rnd_t      in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output f2i8q_pkg::out_beat_t out_data
);
    import f2i8q_pkg::*;

    logic        vld_reg;
    out_beat_t   data_reg;
    out_beat_t   data_next;
    logic [47:0] shifted;
    logic [23:0] m;
    logic [24:0] mr;
    logic [7:0]  mag_raw;
    logic [6:0]  mag;

    always_comb begin
        // align to the 2^-23 grid of 1.0 + a, round to nearest even
        shifted = {in_data.sig, 24'd0} >> in_data.k;
        m       = shifted[47:24] + {23'd0,
                  (shifted[23] && ((shifted[22:0] != 23'd0) || shifted[24]))};
        mr      = {1'b0, m} + 25'h00_8000;
        mag_raw = mr[23:16];
        mag     = (mag_raw > {1'b0, MagMax}) ? MagMax : mag_raw[6:0];
        if (in_data.fixed) begin
            mag = in_data.fixed_mag;
        end
        data_next.last_out  = in_data.last;
        data_next.quantized = in_data.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_ready) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

@@ rtl/core/float_to_int8_quantizer.sv @@
// Channel   Ports                          Carries
// s_        s_valid s_ready s_data         value_bits, last_in
// m_        m_valid m_ready m_data         quantized, last_out
// cfg_      cfg_wr_en cfg_wr_data          scale_bits (IEEE single)
//
// Takes one beat per cycle unless the output stalls; the stages are the 27
// one-bit stages of the pipelined restoring divider plus decode, normalize,
// round and output stages. Every stage holds its own valid bit and advances
// when the next one is empty or moving, so bubbles collapse and a stall
// holds data in place. Reset clears the valid bits and loads scale 1.0.
module float_to_int8_quantizer (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  f2i8q_pkg::in_beat_t   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output f2i8q_pkg::out_beat_t  m_data,
    input  logic                  cfg_wr_en,
    input  logic [31:0]           cfg_wr_data
);
    import f2i8q_pkg::*;

    logic [31:0] scale_reg;
    logic [31:0] scale_next;

    unpack_t up_data;
    logic    up_valid, up_ready;
    work_t   dv_data  [0:QuoBits];
    logic    dv_valid [0:QuoBits];
    logic    dv_ready [0:QuoBits];
    rnd_t    rn_data;
    logic    rn_valid, rn_ready;

    assign scale_next = cfg_wr_en ? cfg_wr_data : scale_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= ScaleReset;
        end else begin
            scale_reg <= scale_next;
        end
    end

    f2i8q_unpack u_unpack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .scale     (scale_reg),
        .out_valid (up_valid),
        .out_ready (up_ready),
        .out_data  (up_data)
    );

    f2i8q_align u_align (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (up_valid),
        .in_ready  (up_ready),
        .in_data   (up_data),
        .out_valid (dv_valid[0]),
        .out_ready (dv_ready[0]),
        .out_data  (dv_data[0])
    );

    for (genvar i = 0; i < QuoBits; i++) begin : g_div
        f2i8q_div_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (dv_valid[i]),
            .in_ready  (dv_ready[i]),
            .in_data   (dv_data[i]),
            .out_valid (dv_valid[i+1]),
            .out_ready (dv_ready[i+1]),
            .out_data  (dv_data[i+1])
        );
    end

    f2i8q_round u_round (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dv_valid[QuoBits]),
        .in_ready  (dv_ready[QuoBits]),
        .in_data   (dv_data[QuoBits]),
        .out_valid (rn_valid),
        .out_ready (rn_ready),
        .out_data  (rn_data)
    );

    f2i8q_pack u_pack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (rn_valid),
        .in_ready  (rn_ready),
        .in_data   (rn_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule

@@ rtl/core/f2i8q_checker.sv @@
// Port-level checks for the quantizer, bound to the top level.
// Depends on f2i8q_pkg and float_to_int8_quantizer.
module f2i8q_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input f2i8q_pkg::out_beat_t m_data
);
    import f2i8q_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // magnitude never exceeds 127
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.quantized != -8'sd128)
        else $error("quantized value out of range");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready after reset");

endmodule

bind float_to_int8_quantizer f2i8q_checker u_f2i8q_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
